### sv/smpbcs_pkg.sv
// package: widths, codes and the sequencer microprogram of the broadcast schedule block
`timescale 1ns / 1ps

package smpbcs_pkg;

  localparam int RANK_W        = 12;
  localparam int SIZE_W        = 13;
  localparam int CORE_W        = 7;
  localparam int DIV_W         = 13;
  localparam int PC_W          = 4;
  localparam int SHK_W         = 4;
  localparam int OFF_W         = 19;
  localparam int MAX_RANKS     = 4096;
  localparam int MAX_CORES     = 64;
  localparam int DEFAULT_CORES = 8;

  typedef enum logic [1:0] {
    KIND_SEND  = 2'd0,
    KIND_RECV  = 2'd1,
    KIND_ERROR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  // micro-operations, one-hot
  typedef enum logic [8:0] {
    A_IDLE    = 9'b000000001,
    A_DIV     = 9'b000000010,
    A_CHECK   = 9'b000000100,
    A_ROOT    = 9'b000001000,
    A_LDINTER = 9'b000010000,
    A_LDINTRA = 9'b000100000,
    A_RECV    = 9'b001000000,
    A_SEND    = 9'b010000000,
    A_FINISH  = 9'b100000000
  } act_t;

  typedef struct packed {
    act_t            act;
    logic [PC_W-1:0] nxt;
    logic [PC_W-1:0] jmp;
  } uword_t;

  localparam logic [PC_W-1:0] PC_IDLE      = 4'd0;
  localparam logic [PC_W-1:0] PC_DIV       = 4'd1;
  localparam logic [PC_W-1:0] PC_CHECK     = 4'd2;
  localparam logic [PC_W-1:0] PC_ROOT      = 4'd3;
  localparam logic [PC_W-1:0] PC_LDINTER   = 4'd4;
  localparam logic [PC_W-1:0] PC_RECVINTER = 4'd5;
  localparam logic [PC_W-1:0] PC_SENDINTER = 4'd6;
  localparam logic [PC_W-1:0] PC_LDINTRA   = 4'd7;
  localparam logic [PC_W-1:0] PC_RECVINTRA = 4'd8;
  localparam logic [PC_W-1:0] PC_SENDINTRA = 4'd9;
  localparam logic [PC_W-1:0] PC_FINISH    = 4'd10;

  // microprogram rom: nxt on plain advance, jmp on taken branch
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{act: A_IDLE, nxt: PC_DIV, jmp: PC_IDLE};
    unique case (pc)
      PC_IDLE:      w = '{act: A_IDLE,    nxt: PC_DIV,       jmp: PC_IDLE};
      PC_DIV:       w = '{act: A_DIV,     nxt: PC_CHECK,     jmp: PC_IDLE};
      PC_CHECK:     w = '{act: A_CHECK,   nxt: PC_ROOT,      jmp: PC_FINISH};
      PC_ROOT:      w = '{act: A_ROOT,    nxt: PC_LDINTER,   jmp: PC_IDLE};
      PC_LDINTER:   w = '{act: A_LDINTER, nxt: PC_RECVINTER, jmp: PC_LDINTRA};
      PC_RECVINTER: w = '{act: A_RECV,    nxt: PC_SENDINTER, jmp: PC_IDLE};
      PC_SENDINTER: w = '{act: A_SEND,    nxt: PC_LDINTRA,   jmp: PC_IDLE};
      PC_LDINTRA:   w = '{act: A_LDINTRA, nxt: PC_RECVINTRA, jmp: PC_IDLE};
      PC_RECVINTRA: w = '{act: A_RECV,    nxt: PC_SENDINTRA, jmp: PC_IDLE};
      PC_SENDINTRA: w = '{act: A_SEND,    nxt: PC_FINISH,    jmp: PC_IDLE};
      PC_FINISH:    w = '{act: A_FINISH,  nxt: PC_IDLE,      jmp: PC_IDLE};
      default:      w = '{act: A_IDLE,    nxt: PC_IDLE,      jmp: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

### sv/smpbcs_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module smpbcs_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [smpbcs_pkg::DIV_W-1:0]       dividend,
  input  logic [smpbcs_pkg::CORE_W-1:0]      divisor,
  output logic                               busy,
  output logic [smpbcs_pkg::DIV_W-1:0]       quot,
  output logic [smpbcs_pkg::CORE_W-1:0]      rem
);

  localparam int CNT_W = $clog2(smpbcs_pkg::DIV_W + 1);

  logic [CNT_W-1:0]                  cnt_r, cnt_nxt;
  logic                              busy_r, busy_nxt;
  logic [smpbcs_pkg::DIV_W-1:0]      acc_r, acc_nxt;
  logic [smpbcs_pkg::CORE_W-1:0]     rem_r, rem_nxt;
  logic [smpbcs_pkg::CORE_W:0]       trial;
  logic [smpbcs_pkg::CORE_W:0]       diff;
  logic                              ge;

  always_comb begin
    trial    = {rem_r, acc_r[smpbcs_pkg::DIV_W-1]};
    ge       = trial >= {1'b0, divisor};
    diff     = trial - {1'b0, divisor};
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    if (start) begin
      cnt_nxt  = CNT_W'(smpbcs_pkg::DIV_W);
      busy_nxt = 1'b1;
      acc_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
      acc_nxt = {acc_r[smpbcs_pkg::DIV_W-2:0], ge};
      rem_nxt = ge ? diff[smpbcs_pkg::CORE_W-1:0] : trial[smpbcs_pkg::CORE_W-1:0];
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
  end

  assign busy = busy_r;
  assign quot = acc_r;
  assign rem  = rem_r;

endmodule

### sv/smp_binomial_bcast_schedule.sv
// top level: two-level binomial broadcast schedule generator, microcoded
`timescale 1ns / 1ps

// channel   dir  beat contents (lsb first)                      handshake
// in_       in   rank[11:0] group_size[24:12] root[36:25]        tvalid/tready
// out_      out  op_kind[1:0] peer_rank[13:2], last on tlast     tvalid/tready
// cfg_      in   cores_per_node[6:0]                             we, no wait
//
// one request at a time: the divide step waits on the 13-bit bit-serial
// divisions, then the microprogram runs one step per cycle while the output
// register does not hold it. reset (synchronous, active low) returns the
// sequencer to its idle step and sets cores_per_node to 8. a full output
// register holds the sequencer when a new operation has to push out the one
// held back for last marking, or when the final beat has to go out.

module smp_binomial_bcast_schedule (
  input  logic        clk,
  input  logic        rst_n,
  // config
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,      // cores_per_node
  // request stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,       // rank[11:0], group_size[24:12], root[36:25], zero pad
  // operation stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,      // op_kind[1:0], peer_rank[13:2], zero pad
  output logic        out_tlast
);

  localparam int RW = smpbcs_pkg::RANK_W;
  localparam int SW = smpbcs_pkg::SIZE_W;
  localparam int CW = smpbcs_pkg::CORE_W;
  localparam int KW = smpbcs_pkg::SHK_W;
  localparam int OW = smpbcs_pkg::OFF_W;

  // sequencer step counter and the current control word
  logic [smpbcs_pkg::PC_W-1:0] pc_r, pc_nxt;
  smpbcs_pkg::uword_t          uw;

  // config register
  logic [CW-1:0] cores_cfg_r;
  logic [CW-1:0] cores_eff;

  // request latched at accept
  logic [RW-1:0] rank_r, root_r;
  logic [SW-1:0] size_r;
  logic [CW-1:0] cores_r;

  // tree walker: remaining send levels, pending receive, stride unit
  logic [KW-1:0] k_r, k_nxt;
  logic          recv_r, recv_nxt;
  logic [CW-1:0] unit_r, unit_nxt;

  // held-back operation, so that the final one can carry last
  logic                pend_v_r, pend_v_nxt;
  smpbcs_pkg::kind_t   pend_kind_r, pend_kind_nxt;
  logic [RW-1:0]       pend_peer_r, pend_peer_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  smpbcs_pkg::kind_t   out_kind_r, out_kind_nxt;
  logic [RW-1:0]       out_peer_r, out_peer_nxt;
  logic                out_last_r, out_last_nxt;

  // divider results
  logic          in_acc;
  logic          div_start;
  logic          busy_rank, busy_size;
  logic [SW-1:0] rank_q, size_q;
  logic [CW-1:0] rank_rem, size_rem;

  logic [RW-1:0] node_idx, node_cnt;
  logic [5:0]    core_idx;
  logic          err;

  // tree arithmetic
  logic [RW-1:0] ld_pos, ld_tsize;
  logic [KW-1:0] ld_cnt;
  logic [KW-1:0] sh_amt;
  logic [OW-1:0] off;
  logic [OW-1:0] to_rank;
  logic          send_ok;
  logic [RW-1:0] recv_peer;

  // step control
  logic              gen, fin, adv, br, go, push_out, ld;
  smpbcs_pkg::kind_t gen_kind;
  logic [RW-1:0]     gen_peer;

  // smallest n with 2**n >= v, v >= 1
  function automatic logic [KW-1:0] ceil_log2(input logic [RW-1:0] v);
    logic [RW-1:0] m;
    logic [KW-1:0] n;
    m = v - 1'b1;
    n = '0;
    for (int i = 0; i < RW; i++) begin
      if (m[i]) n = KW'(i + 1);
    end
    return n;
  endfunction

  // index of the lowest set bit, v nonzero
  function automatic logic [KW-1:0] low_bit(input logic [RW-1:0] v);
    logic [KW-1:0] n;
    n = '0;
    for (int i = RW - 1; i >= 0; i--) begin
      if (v[i]) n = KW'(i);
    end
    return n;
  endfunction

  // zero and one fall back to the default, anything above the ceiling saturates
  always_comb begin
    if (cores_cfg_r <= CW'(1)) begin
      cores_eff = CW'(smpbcs_pkg::DEFAULT_CORES);
    end else if (cores_cfg_r > CW'(smpbcs_pkg::MAX_CORES)) begin
      cores_eff = CW'(smpbcs_pkg::MAX_CORES);
    end else begin
      cores_eff = cores_cfg_r;
    end
  end

  assign uw        = smpbcs_pkg::ucode(pc_r);
  assign in_tready = (uw.act == smpbcs_pkg::A_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  smpbcs_div u_div_rank (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({1'b0, in_tdata[11:0]}),
    .divisor  (cores_eff),
    .busy     (busy_rank),
    .quot     (rank_q),
    .rem      (rank_rem)
  );

  smpbcs_div u_div_size (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_tdata[24:12]),
    .divisor  (cores_eff),
    .busy     (busy_size),
    .quot     (size_q),
    .rem      (size_rem)
  );

  // node coordinates; the quotients fit 12 bits whenever the request is valid
  assign node_idx = rank_q[RW-1:0];
  assign node_cnt = size_q[RW-1:0];
  assign core_idx = rank_rem[5:0];

  assign err = (size_r > SW'(smpbcs_pkg::MAX_RANKS)) || ({1'b0, rank_r} >= size_r) ||
               ({1'b0, root_r} >= size_r) || (size_rem != '0);

  // tree load: a non-root position receives once, then sends below its lowest
  // set bit; position zero sends on every level of the tree
  always_comb begin
    if (uw.act == smpbcs_pkg::A_LDINTER) begin
      ld_pos   = node_idx;
      ld_tsize = node_cnt;
    end else begin
      ld_pos   = RW'(core_idx);
      ld_tsize = RW'(cores_r);
    end
    ld_cnt = (ld_pos != '0) ? low_bit(ld_pos) : ceil_log2(ld_tsize);
  end

  // peer = rank +/- unit << level; a send past the group end is dropped
  assign sh_amt    = (uw.act == smpbcs_pkg::A_SEND) ? (k_r - 1'b1) : k_r;
  assign off       = OW'(unit_r) << sh_amt;
  assign to_rank   = OW'(rank_r) + off;
  assign send_ok   = to_rank < OW'(size_r);
  assign recv_peer = rank_r - off[RW-1:0];

  always_comb begin
    gen       = 1'b0;
    gen_kind  = smpbcs_pkg::KIND_SEND;
    gen_peer  = '0;
    fin       = 1'b0;
    adv       = 1'b0;
    br        = 1'b0;
    ld        = 1'b0;
    div_start = 1'b0;
    unique case (uw.act)
      smpbcs_pkg::A_IDLE: begin
        adv       = in_tvalid;
        div_start = in_acc;
      end
      smpbcs_pkg::A_DIV: begin
        adv = !(busy_rank || busy_size);
      end
      smpbcs_pkg::A_CHECK: begin
        if (err) begin
          gen      = 1'b1;
          gen_kind = smpbcs_pkg::KIND_ERROR;
          br       = 1'b1;
        end else begin
          adv = 1'b1;
        end
      end
      smpbcs_pkg::A_ROOT: begin
        // nonzero root hands the data to rank 0 first
        if (root_r != '0 && rank_r == root_r) begin
          gen      = 1'b1;
          gen_kind = smpbcs_pkg::KIND_SEND;
        end else if (root_r != '0 && rank_r == '0) begin
          gen      = 1'b1;
          gen_kind = smpbcs_pkg::KIND_RECV;
          gen_peer = root_r;
        end
        adv = 1'b1;
      end
      smpbcs_pkg::A_LDINTER: begin
        // only node leaders take part in the leader tree
        if (core_idx != '0) begin
          br = 1'b1;
        end else begin
          ld  = 1'b1;
          adv = 1'b1;
        end
      end
      smpbcs_pkg::A_LDINTRA: begin
        ld  = 1'b1;
        adv = 1'b1;
      end
      smpbcs_pkg::A_RECV: begin
        if (recv_r) begin
          gen      = 1'b1;
          gen_kind = smpbcs_pkg::KIND_RECV;
          gen_peer = recv_peer;
        end
        adv = 1'b1;
      end
      smpbcs_pkg::A_SEND: begin
        if (k_r != '0 && send_ok) begin
          gen      = 1'b1;
          gen_kind = smpbcs_pkg::KIND_SEND;
          gen_peer = to_rank[RW-1:0];
        end
        adv = (k_r <= KW'(1));
      end
      smpbcs_pkg::A_FINISH: begin
        fin = 1'b1;
        adv = 1'b1;
      end
      default: begin
        adv = 1'b0;
      end
    endcase
  end

  // hold the step only when the output register must take a beat and cannot
  assign go = !(((gen && pend_v_r) || fin) && out_valid_r && !out_tready);
  assign push_out = go && ((gen && pend_v_r) || fin);

  always_comb begin
    pc_nxt = pc_r;
    if (go) begin
      if (br) begin
        pc_nxt = uw.jmp;
      end else if (adv) begin
        pc_nxt = uw.nxt;
      end
    end

    k_nxt    = k_r;
    recv_nxt = recv_r;
    unit_nxt = unit_r;
    if (ld) begin
      k_nxt    = ld_cnt;
      recv_nxt = (ld_pos != '0);
      unit_nxt = (uw.act == smpbcs_pkg::A_LDINTER) ? cores_r : CW'(1);
    end else if (go && uw.act == smpbcs_pkg::A_SEND && k_r != '0) begin
      k_nxt = k_r - 1'b1;
    end

    pend_v_nxt    = pend_v_r;
    pend_kind_nxt = pend_kind_r;
    pend_peer_nxt = pend_peer_r;
    if (go && gen) begin
      pend_v_nxt    = 1'b1;
      pend_kind_nxt = gen_kind;
      pend_peer_nxt = gen_peer;
    end else if (go && fin) begin
      pend_v_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_peer_nxt  = out_peer_r;
    out_last_nxt  = out_last_r;
    if (push_out) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = fin;
      if (fin && !pend_v_r) begin
        out_kind_nxt = smpbcs_pkg::KIND_NONE;
        out_peer_nxt = '0;
      end else begin
        out_kind_nxt = pend_kind_r;
        out_peer_nxt = pend_peer_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= smpbcs_pkg::PC_IDLE;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      cores_cfg_r <= CW'(smpbcs_pkg::DEFAULT_CORES);
    end else begin
      pc_r        <= pc_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cores_cfg_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rank_r  <= in_tdata[11:0];
      size_r  <= in_tdata[24:12];
      root_r  <= in_tdata[36:25];
      cores_r <= cores_eff;
    end
    k_r         <= k_nxt;
    recv_r      <= recv_nxt;
    unit_r      <= unit_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_peer_r <= pend_peer_nxt;
    out_kind_r  <= out_kind_nxt;
    out_peer_r  <= out_peer_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_peer_r, out_kind_r};
  assign out_tlast  = out_last_r;

endmodule

### sv/smpbcs_chk.sv
// port-level checker for the broadcast schedule block, with its bind
`timescale 1ns / 1ps

module smpbcs_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [39:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  // a stalled result beat holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result beat changed");

  // only one request in flight
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while another is in work");

  // error and none stand alone with a zero peer
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == smpbcs_pkg::KIND_ERROR ||
                   out_tdata[1:0] == smpbcs_pkg::KIND_NONE)
    |-> out_tlast && out_tdata[13:2] == '0)
    else $error("error or none beat malformed");

  // nothing left over after reset
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind smp_binomial_bcast_schedule smpbcs_chk u_smpbcs_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
